// ----- src/rc4_pkg.sv -----
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants, register indexes, sequencer states and the control and
// status structs that pass between the RC4 sequencer and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

  localparam int BYTE_W        = 8;
  localparam int PERM_DEPTH    = 256;
  localparam int PERM_AW       = $clog2(PERM_DEPTH);
  localparam int MAX_KEY_BYTES = 16;
  localparam int KIDX_W        = $clog2(MAX_KEY_BYTES);
  localparam int KEY_W         = 2 * 64;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int KLEN_W        = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 5'd16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KS_RD_N,
    ST_KS_RD_J,
    ST_KS_WR_N,
    ST_KS_WR_J,
    ST_G_RD_I,
    ST_G_RD_J,
    ST_G_WR_I,
    ST_G_WR_J,
    ST_G_RD_K,
    ST_G_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    ADD_ACC_KEY,
    ADD_I_INC,
    ADD_J_S,
    ADD_A_B
  } add_op_t;

  typedef enum logic {
    RD_N,
    RD_SUM
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_N_RDV,
    WR_ACC_A,
    WR_I_RDV,
    WR_J_A
  } wr_sel_t;

  typedef struct packed {
    logic    ks_start;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    we;
    wr_sel_t wr_sel;
    add_op_t add_op;
    logic    upd_acc;
    logic    upd_i;
    logic    upd_j;
    logic    cap_a;
    logic    cap_b;
    logic    step_n;
  } dp_ctrl_t;

  typedef struct packed {
    logic n_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- src/rc4_in_if.sv -----
// ----------------------------------------------------------------------------
// rc4_in_if
// Input channel: one data word with its start-of-message flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_message;

  modport source (output valid, output data_byte, output first_of_message, input ready);
  modport sink   (input valid, input data_byte, input first_of_message, output ready);
endinterface

`default_nettype wire

// ----- src/rc4_out_if.sv -----
// ----------------------------------------------------------------------------
// rc4_out_if
// Result channel: ciphered word and the keystream word used for it.
// ----------------------------------------------------------------------------
`default_nettype none

interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic [7:0] keystream_out;

  modport source (output valid, output cipher_byte, output keystream_out, input ready);
  modport sink   (input valid, input cipher_byte, input keystream_out, output ready);
endinterface

`default_nettype wire

// ----- src/rc4_ram.sv -----
// ----------------------------------------------------------------------------
// rc4_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/rc4_seq.sv -----
// ----------------------------------------------------------------------------
// rc4_seq
// Sequencer for the key schedule and the output generator. Each step of
// either loop is split into reads and writes of the two-port permutation.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_seq import rc4_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_accept,
  input  wire logic     in_first,
  input  wire logic     out_free,
  input  wire dp_stat_t stat,
  output logic          in_ready,
  output logic          out_load,
  output dp_ctrl_t      ctrl
);

  seq_state_t state_r;
  seq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = in_first ? ST_KS_RD_N : ST_G_RD_I;
        end
      end
      ST_KS_RD_N: state_nxt = ST_KS_RD_J;
      ST_KS_RD_J: state_nxt = ST_KS_WR_N;
      ST_KS_WR_N: state_nxt = ST_KS_WR_J;
      ST_KS_WR_J: state_nxt = stat.n_last ? ST_G_RD_I : ST_KS_RD_N;
      ST_G_RD_I:  state_nxt = ST_G_RD_J;
      ST_G_RD_J:  state_nxt = ST_G_WR_I;
      ST_G_WR_I:  state_nxt = ST_G_WR_J;
      ST_G_WR_J:  state_nxt = ST_G_RD_K;
      ST_G_RD_K:  state_nxt = ST_G_OUT;
      ST_G_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    ctrl     = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        ctrl.ks_start = in_accept & in_first;
      end
      ST_KS_RD_N: begin
        ctrl.rd_en  = 1'b1;
        ctrl.rd_sel = RD_N;
      end
      ST_KS_RD_J: begin
        ctrl.add_op  = ADD_ACC_KEY;
        ctrl.upd_acc = 1'b1;
        ctrl.cap_a   = 1'b1;
        ctrl.rd_en   = 1'b1;
        ctrl.rd_sel  = RD_SUM;
      end
      ST_KS_WR_N: begin
        ctrl.we     = 1'b1;
        ctrl.wr_sel = WR_N_RDV;
      end
      ST_KS_WR_J: begin
        ctrl.we     = 1'b1;
        ctrl.wr_sel = WR_ACC_A;
        ctrl.step_n = 1'b1;
      end
      ST_G_RD_I: begin
        ctrl.add_op = ADD_I_INC;
        ctrl.upd_i  = 1'b1;
        ctrl.rd_en  = 1'b1;
        ctrl.rd_sel = RD_SUM;
      end
      ST_G_RD_J: begin
        ctrl.add_op = ADD_J_S;
        ctrl.upd_j  = 1'b1;
        ctrl.cap_a  = 1'b1;
        ctrl.rd_en  = 1'b1;
        ctrl.rd_sel = RD_SUM;
      end
      ST_G_WR_I: begin
        ctrl.we     = 1'b1;
        ctrl.wr_sel = WR_I_RDV;
        ctrl.cap_b  = 1'b1;
      end
      ST_G_WR_J: begin
        ctrl.we     = 1'b1;
        ctrl.wr_sel = WR_J_A;
      end
      ST_G_RD_K: begin
        ctrl.add_op = ADD_A_B;
        ctrl.rd_en  = 1'b1;
        ctrl.rd_sel = RD_SUM;
      end
      ST_G_OUT: begin
        out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/rc4_dp.sv -----
// ----------------------------------------------------------------------------
// rc4_dp
// Datapath: permutation RAM with per-entry valid bits, the indices, the
// key-schedule accumulator and one shared three-input byte adder.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_dp import rc4_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dp_ctrl_t          ctrl,
  input  wire logic [KEY_W-1:0]  key,
  input  wire logic [KIDX_W-1:0] key_last,
  output dp_stat_t               stat,
  output logic [BYTE_W-1:0]      rd_value
);

  logic [PERM_DEPTH-1:0] valid_r;
  logic [PERM_AW-1:0]    n_r;
  logic [KIDX_W-1:0]     kidx_r;
  logic [BYTE_W-1:0]     acc_r;
  logic [PERM_AW-1:0]    i_r;
  logic [PERM_AW-1:0]    j_r;
  logic [BYTE_W-1:0]     a_r;
  logic [BYTE_W-1:0]     b_r;
  logic [PERM_AW-1:0]    rd_addr_r;
  logic                  rd_valid_r;
  logic [BYTE_W-1:0]     ram_q;

  logic [BYTE_W-1:0]     op_a;
  logic [BYTE_W-1:0]     op_b;
  logic [BYTE_W-1:0]     op_c;
  logic [BYTE_W-1:0]     sum;
  logic [BYTE_W-1:0]     key_byte;
  logic [PERM_AW-1:0]    raddr;
  logic [PERM_AW-1:0]    waddr;
  logic [BYTE_W-1:0]     wdata;

  assign key_byte = key[kidx_r*BYTE_W +: BYTE_W];

  // The one adder serves the i, j and accumulator updates and the read addresses.
  always_comb begin
    case (ctrl.add_op)
      ADD_ACC_KEY: begin op_a = acc_r; op_b = rd_value; op_c = key_byte; end
      ADD_I_INC:   begin op_a = i_r;   op_b = '0;       op_c = 8'd1;     end
      ADD_J_S:     begin op_a = j_r;   op_b = rd_value; op_c = '0;       end
      ADD_A_B:     begin op_a = a_r;   op_b = b_r;      op_c = '0;       end
      default:     begin op_a = '0;    op_b = '0;       op_c = '0;       end
    endcase
  end

  assign sum = BYTE_W'(op_a + op_b + op_c);

  assign raddr = (ctrl.rd_sel == RD_N) ? n_r : sum;

  always_comb begin
    case (ctrl.wr_sel)
      WR_N_RDV: begin waddr = n_r;   wdata = rd_value; end
      WR_ACC_A: begin waddr = acc_r; wdata = a_r;      end
      WR_I_RDV: begin waddr = i_r;   wdata = rd_value; end
      WR_J_A:   begin waddr = j_r;   wdata = a_r;      end
      default:  begin waddr = '0;    wdata = '0;       end
    endcase
  end

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PERM_DEPTH)
  ) u_perm (
    .clk   (clk),
    .we    (ctrl.we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctrl.rd_en),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // An entry never written since reset or since the last key schedule
  // holds its own index.
  assign rd_value = rd_valid_r ? ram_q : rd_addr_r;

  assign stat.n_last = (n_r == PERM_AW'(PERM_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      n_r     <= '0;
      kidx_r  <= '0;
      acc_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
    end else if (ctrl.ks_start) begin
      valid_r <= '0;
      n_r     <= '0;
      kidx_r  <= '0;
      acc_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      if (ctrl.we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (ctrl.upd_acc) begin
        acc_r <= sum;
      end
      if (ctrl.upd_i) begin
        i_r <= sum;
      end
      if (ctrl.upd_j) begin
        j_r <= sum;
      end
      if (ctrl.step_n) begin
        n_r    <= n_r + 1'b1;
        kidx_r <= (kidx_r == key_last) ? '0 : kidx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_addr_r  <= raddr;
      rd_valid_r <= valid_r[raddr];
    end
    if (ctrl.cap_a) begin
      a_r <= rd_value;
    end
    if (ctrl.cap_b) begin
      b_r <= rd_value;
    end
  end

endmodule

`default_nettype wire

// ----- src/rc4_stream_cipher.sv -----
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 stream cipher, one data word in and one ciphered word out per item.
// A word flagged as first of a message reruns the key schedule first.
// ----------------------------------------------------------------------------
//   Channel   Direction  Contents
//   in_ch     sink       data_byte, first_of_message
//   out_ch    source     cipher_byte, keystream_out
//   cfg_*     write      key_bytes_low, key_bytes_high, key_length
//
// A word runs the generator states RD_I, RD_J, WR_I, WR_J, RD_K and OUT; a
// first word first runs the key schedule states RD_N, RD_J, WR_N, WR_J per entry.
// The split is set by the single read and single write port of the RAM.
// Reset restores the identity permutation at once through per-entry valid
// bits; there is no clearing pass. A stalled result waits in the output
// register and the next word is taken meanwhile; the block only holds its
// own result back when that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher import rc4_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  rc4_in_if.sink                    in_ch,
  rc4_out_if.source                 out_ch
);

  logic [CFG_W-1:0]  key_low_r;
  logic [CFG_W-1:0]  key_high_r;
  logic [KLEN_W-1:0] key_len_r;
  logic [KIDX_W-1:0] key_last;

  logic [BYTE_W-1:0] data_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [BYTE_W-1:0] cipher_r;
  logic [BYTE_W-1:0] ks_r;

  logic              in_ready;
  logic              in_accept;
  logic              out_free;
  logic              out_load;
  dp_ctrl_t          ctrl;
  dp_stat_t          stat;
  logic [BYTE_W-1:0] rd_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      key_len_r  <= KLEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        CFG_KEY_HIGH: key_high_r <= cfg_wdata;
        CFG_KEY_LEN:  key_len_r  <= cfg_wdata[KLEN_W-1:0];
        default:      key_len_r  <= key_len_r;
      endcase
    end
  end

  // Index of the last key byte in use, with the length saturated to 1..16.
  always_comb begin
    if (key_len_r == '0) begin
      key_last = '0;
    end else if (key_len_r > KLEN_W'(MAX_KEY_BYTES)) begin
      key_last = KIDX_W'(MAX_KEY_BYTES - 1);
    end else begin
      key_last = KIDX_W'(key_len_r - 1'b1);
    end
  end

  assign in_ch.ready = in_ready;
  assign in_accept   = in_ch.valid & in_ready;
  assign out_free    = ~out_valid_r | out_ch.ready;

  rc4_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_first  (in_ch.first_of_message),
    .out_free  (out_free),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_load  (out_load),
    .ctrl      (ctrl)
  );

  rc4_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .key      ({key_high_r, key_low_r}),
    .key_last (key_last),
    .stat     (stat),
    .rd_value (rd_value)
  );

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      data_r <= in_ch.data_byte;
    end
    if (out_load) begin
      cipher_r <= data_r ^ rd_value;
      ks_r     <= rd_value;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.cipher_byte   = cipher_r;
  assign out_ch.keystream_out = ks_r;

endmodule

`default_nettype wire

// ----- src/rc4_checker.sv -----
// ----------------------------------------------------------------------------
// rc4_checker
// Port-level checks on the RC4 block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_first,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] cipher_byte,
  input wire logic [7:0] keystream_out
);

  // The block works on one word at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a word was accepted");

  // A key schedule keeps the block busy after a first word is accepted.
  a_key_schedule_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_first |-> ##4 !in_ready)
    else $error("key schedule finished too early");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cipher_byte) && $stable(keystream_out))
    else $error("stalled result changed or dropped");

  // Out of reset the block is empty and ready.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty and ready after reset");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_first      (in_ch.first_of_message),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .cipher_byte   (out_ch.cipher_byte),
  .keystream_out (out_ch.keystream_out)
);

`default_nettype wire
